@@ rtl/i2cmws_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cmws_pkg
// Shared types and constants for the I2C master write sequencer.
// ----------------------------------------------------------------------------
package i2cmws_pkg;

  // Delay counter width default and reset value of the half-period register
  localparam int unsigned DELAY_WIDTH_DEF   = 16;
  localparam int unsigned HALF_PERIOD_W     = 16;
  localparam logic [HALF_PERIOD_W-1:0] HALF_PERIOD_RESET = 16'd5;

  // Depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH_DEF   = 2;

  // Raw opcodes on the input word
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_STOP  = 2'd1;
  localparam logic [1:0] OP_SEND  = 2'd2;

  // Command class after decode; NONE covers no command and unused opcodes
  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2,
    CMD_SEND  = 2'd3
  } cmd_kind_t;

  // One classified tick as it travels through the queue
  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data_byte;
    logic       sda_in;
  } item_t;

endpackage

@@ rtl/i2cmws_front.sv @@
// ----------------------------------------------------------------------------
// i2cmws_front
// Input side: decodes each tick word into a command class for the queue.
// ----------------------------------------------------------------------------
module i2cmws_front (
  input  logic               in_cmd_valid,
  input  logic [1:0]         in_opcode,
  input  logic [7:0]         in_data_byte,
  input  logic               in_sda_in,
  output i2cmws_pkg::item_t  item
);
  import i2cmws_pkg::*;

  cmd_kind_t kind;

  always_comb begin
    kind = CMD_NONE;
    if (in_cmd_valid) begin
      unique case (in_opcode)
        OP_START: kind = CMD_START;
        OP_STOP:  kind = CMD_STOP;
        OP_SEND:  kind = CMD_SEND;
        default:  kind = CMD_NONE;  // opcode three decodes as no command
      endcase
    end
  end

  assign item.kind      = kind;
  assign item.data_byte = in_data_byte;
  assign item.sda_in    = in_sda_in;

endmodule

@@ rtl/i2cmws_queue.sv @@
// ----------------------------------------------------------------------------
// i2cmws_queue
// Small FIFO of classified tick words between front and back.
// ----------------------------------------------------------------------------
module i2cmws_queue #(
  parameter int unsigned DEPTH = i2cmws_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  i2cmws_pkg::item_t  push_item,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output i2cmws_pkg::item_t  head_item
);
  import i2cmws_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  item_t         mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r,  count_nxt;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head_item = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    priority if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end else begin
      count_nxt = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

@@ rtl/i2cmws_back.sv @@
// ----------------------------------------------------------------------------
// i2cmws_back
// Pin sequencer: one queued tick per step, state doubles as the result word.
// ----------------------------------------------------------------------------
module i2cmws_back #(
  parameter int unsigned DELAY_WIDTH = i2cmws_pkg::DELAY_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [i2cmws_pkg::HALF_PERIOD_W-1:0] half_period,
  input  logic                                item_avail,
  input  i2cmws_pkg::item_t                   item,
  output logic                                item_pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_scl_out,
  output logic                                out_sda_out,
  output logic                                out_busy_res,
  output logic                                out_done_res,
  output logic                                out_ack_received
);
  import i2cmws_pkg::*;

  typedef enum logic [8:0] {
    PH_IDLE    = 9'b0_0000_0001,
    PH_ST_A    = 9'b0_0000_0010,
    PH_ST_B    = 9'b0_0000_0100,
    PH_SP_A    = 9'b0_0000_1000,
    PH_SP_B    = 9'b0_0001_0000,
    PH_TX_LOW  = 9'b0_0010_0000,
    PH_TX_HIGH = 9'b0_0100_0000,
    PH_AK_LOW  = 9'b0_1000_0000,
    PH_AK_HIGH = 9'b1_0000_0000
  } phase_t;

  phase_t                 phase_r,  phase_nxt;
  logic [DELAY_WIDTH-1:0] dly_r,    dly_nxt;
  logic [3:0]             bits_r,   bits_nxt;
  logic [7:0]             shift_r,  shift_nxt;
  logic                   scl_r,    scl_nxt;
  logic                   sda_r,    sda_nxt;
  logic                   ack_r,    ack_nxt;
  logic                   done_r,   done_nxt;
  logic                   ovld_r;

  logic [DELAY_WIDTH-1:0] wait_raw, wait_len, dly_dec;
  logic                   expire;
  logic                   step;

  // Step when a tick is queued and the result slot is free or being drained
  assign step     = item_avail && (!ovld_r || out_ready);
  assign item_pop = step;

  assign wait_raw = DELAY_WIDTH'(half_period);
  assign wait_len = (wait_raw == '0) ? DELAY_WIDTH'(1) : wait_raw;
  assign dly_dec  = (dly_r != '0) ? dly_r - 1'b1 : dly_r;
  assign expire   = (dly_dec == '0);

  always_comb begin
    phase_nxt = phase_r;
    dly_nxt   = dly_r;
    bits_nxt  = bits_r;
    shift_nxt = shift_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    ack_nxt   = ack_r;
    done_nxt  = 1'b0;
    unique case (phase_r)
      PH_IDLE: begin
        unique case (item.kind)
          CMD_START: begin
            sda_nxt   = 1'b1;
            scl_nxt   = 1'b1;
            phase_nxt = PH_ST_A;
            dly_nxt   = wait_len;
          end
          CMD_STOP: begin
            sda_nxt   = 1'b0;
            scl_nxt   = 1'b1;
            phase_nxt = PH_SP_A;
            dly_nxt   = wait_len;
          end
          CMD_SEND: begin
            sda_nxt   = item.data_byte[7];
            shift_nxt = {item.data_byte[6:0], 1'b0};
            bits_nxt  = 4'd1;
            phase_nxt = PH_TX_LOW;
            dly_nxt   = wait_len;
          end
          default: ;
        endcase
      end
      PH_ST_A, PH_ST_B, PH_SP_A, PH_SP_B,
      PH_TX_LOW, PH_TX_HIGH, PH_AK_LOW, PH_AK_HIGH: begin
        dly_nxt = dly_dec;
        if (expire) begin
          unique case (phase_r)
            PH_ST_A: begin
              sda_nxt   = 1'b0;
              phase_nxt = PH_ST_B;
              dly_nxt   = wait_len;
            end
            PH_ST_B: begin
              scl_nxt   = 1'b0;
              phase_nxt = PH_IDLE;
              done_nxt  = 1'b1;
            end
            PH_SP_A: begin
              sda_nxt   = 1'b1;
              phase_nxt = PH_SP_B;
              dly_nxt   = wait_len;
            end
            PH_SP_B: begin
              phase_nxt = PH_IDLE;
              done_nxt  = 1'b1;
            end
            PH_TX_LOW: begin
              scl_nxt   = 1'b1;
              phase_nxt = PH_TX_HIGH;
              dly_nxt   = wait_len;
            end
            PH_TX_HIGH: begin
              scl_nxt = 1'b0;
              dly_nxt = wait_len;
              if (bits_r < 4'd8) begin
                sda_nxt   = shift_r[7];
                shift_nxt = {shift_r[6:0], 1'b0};
                bits_nxt  = bits_r + 1'b1;
                phase_nxt = PH_TX_LOW;
              end else begin
                sda_nxt   = 1'b1;   // let go of SDA for the ack clock
                phase_nxt = PH_AK_LOW;
              end
            end
            PH_AK_LOW: begin
              scl_nxt   = 1'b1;
              phase_nxt = PH_AK_HIGH;
              dly_nxt   = wait_len;
            end
            default: begin          // ack high: sample and finish
              ack_nxt   = ~item.sda_in;
              scl_nxt   = 1'b0;
              phase_nxt = PH_IDLE;
              done_nxt  = 1'b1;
            end
          endcase
        end
      end
      default: begin                // corrupt phase
        phase_nxt = PH_IDLE;
        dly_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      dly_r   <= '0;
      bits_r  <= '0;
      shift_r <= '0;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
      ack_r   <= 1'b0;
      done_r  <= 1'b0;
      ovld_r  <= 1'b0;
    end else begin
      if (step) begin
        phase_r <= phase_nxt;
        dly_r   <= dly_nxt;
        bits_r  <= bits_nxt;
        shift_r <= shift_nxt;
        scl_r   <= scl_nxt;
        sda_r   <= sda_nxt;
        ack_r   <= ack_nxt;
        done_r  <= done_nxt;
        ovld_r  <= 1'b1;
      end else if (out_ready) begin
        ovld_r  <= 1'b0;
      end
    end
  end

  assign out_valid        = ovld_r;
  assign out_scl_out      = scl_r;
  assign out_sda_out      = sda_r;
  assign out_busy_res     = (phase_r != PH_IDLE);
  assign out_done_res     = done_r;
  assign out_ack_received = ack_r;

endmodule

@@ rtl/i2c_master_write_sequencer.sv @@
// ----------------------------------------------------------------------------
// i2c_master_write_sequencer
// I2C master pin sequencer for START, STOP and byte SEND with ack sample.
// ----------------------------------------------------------------------------
// Each input word is one tick of the bus sequencer and yields exactly one
// result word holding the SCL/SDA drive levels, busy, done and the last ack.
// Words move at one per clock while out_ready holds: the front decodes a word
// and pushes it into a queue (two entries by default), the back pops one word
// per clock into its result register unless out_ready stalls it. With the
// queue empty and the result register free, an accepted input word is first
// written into the queue and then stepped into the result register.
// The half-period register (reset 5, zero treated as one) sets
// how many ticks each bus phase lasts; write it only while no command runs.
// The config port is always ready.
// ----------------------------------------------------------------------------
module i2c_master_write_sequencer #(
  parameter int unsigned DELAY_WIDTH = i2cmws_pkg::DELAY_WIDTH_DEF,
  parameter int unsigned QUEUE_DEPTH = i2cmws_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // tick input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_cmd_valid,
  input  logic [1:0]                          in_opcode,
  input  logic [7:0]                          in_data_byte,
  input  logic                                in_sda_in,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_scl_out,
  output logic                                out_sda_out,
  output logic                                out_busy_res,
  output logic                                out_done_res,
  output logic                                out_ack_received,
  // half-period register write
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [i2cmws_pkg::HALF_PERIOD_W-1:0] cfg_half_period_ticks
);
  import i2cmws_pkg::*;

  logic [HALF_PERIOD_W-1:0] half_period_r;

  item_t front_item;
  item_t head_item;
  logic  q_full;
  logic  q_not_empty;
  logic  q_pop;
  logic  q_push;

  // Config register, taken on any valid write
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r <= HALF_PERIOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      half_period_r <= cfg_half_period_ticks;
    end
  end

  // Front: classify the incoming word
  i2cmws_front u_front (
    .in_cmd_valid (in_cmd_valid),
    .in_opcode    (in_opcode),
    .in_data_byte (in_data_byte),
    .in_sda_in    (in_sda_in),
    .item         (front_item)
  );

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  // Queue decouples input stalls from result stalls
  i2cmws_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_item (head_item)
  );

  // Back: the bus sequencer proper
  i2cmws_back #(
    .DELAY_WIDTH (DELAY_WIDTH)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .half_period      (half_period_r),
    .item_avail       (q_not_empty),
    .item             (head_item),
    .item_pop         (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_scl_out      (out_scl_out),
    .out_sda_out      (out_sda_out),
    .out_busy_res     (out_busy_res),
    .out_done_res     (out_done_res),
    .out_ack_received (out_ack_received)
  );

endmodule
